// ===== rtl/stepping_rotor_cipher_top_defines.svh =====
// Assertion macros for the rotor cipher block.
`ifndef STEPPING_ROTOR_CIPHER_TOP_DEFINES_SVH
`define STEPPING_ROTOR_CIPHER_TOP_DEFINES_SVH

// Clocked assertion, disabled while reset is active.
`define SRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/src_pkg.sv =====
package src_pkg;

  localparam int unsigned LETTERS = 26;
  localparam int unsigned IdxW = (LETTERS > 1) ? $clog2(LETTERS) : 1;
  localparam int unsigned OffsetReset = 20 % LETTERS;

  typedef enum logic [1:0] {
    ActEncrypt = 2'd0,
    ActDecrypt = 2'd1,
    ActLoad    = 2'd2,
    ActAlign   = 2'd3
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [4:0] letter;
    logic [4:0] slot;
  } in_req_t;

  typedef struct packed {
    logic [4:0] out_letter;
    logic       found;
  } out_res_t;

  // Default wiring: w r y i p k h f s z c b m q n e v t x u a o d l g j.
  // Entries past the 26 defaults hold their own index.
  function automatic logic [4:0] default_wiring(input logic [4:0] idx);
    logic [4:0] r;
    case (idx)
      5'd0:    r = 5'd22;
      5'd1:    r = 5'd17;
      5'd2:    r = 5'd24;
      5'd3:    r = 5'd8;
      5'd4:    r = 5'd15;
      5'd5:    r = 5'd10;
      5'd6:    r = 5'd7;
      5'd7:    r = 5'd5;
      5'd8:    r = 5'd18;
      5'd9:    r = 5'd25;
      5'd10:   r = 5'd2;
      5'd11:   r = 5'd1;
      5'd12:   r = 5'd12;
      5'd13:   r = 5'd16;
      5'd14:   r = 5'd13;
      5'd15:   r = 5'd4;
      5'd16:   r = 5'd21;
      5'd17:   r = 5'd19;
      5'd18:   r = 5'd23;
      5'd19:   r = 5'd20;
      5'd20:   r = 5'd0;
      5'd21:   r = 5'd14;
      5'd22:   r = 5'd3;
      5'd23:   r = 5'd11;
      5'd24:   r = 5'd6;
      5'd25:   r = 5'd9;
      default: r = idx;
    endcase
    return r;
  endfunction

  // (a + b) mod LETTERS, both operands already below LETTERS.
  function automatic logic [IdxW-1:0] add_mod(input logic [IdxW-1:0] a,
                                              input logic [IdxW-1:0] b);
    logic [IdxW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IdxW+1)'(LETTERS)) s = s - (IdxW+1)'(LETTERS);
    return s[IdxW-1:0];
  endfunction

  // (a - b) mod LETTERS, both operands already below LETTERS.
  function automatic logic [IdxW-1:0] sub_mod(input logic [IdxW-1:0] a,
                                              input logic [IdxW-1:0] b);
    logic [IdxW:0] s;
    s = {1'b0, a} + (IdxW+1)'(LETTERS) - {1'b0, b};
    if (s >= (IdxW+1)'(LETTERS)) s = s - (IdxW+1)'(LETTERS);
    return s[IdxW-1:0];
  endfunction

  // 5-bit key reduced mod LETTERS, as a 32-entry lookup.
  function automatic logic [IdxW-1:0] key_mod(input logic [4:0] k);
    logic [IdxW-1:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (k == 5'(i)) r = IdxW'(i % LETTERS);
    end
    return r;
  endfunction

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [IdxW-1:0] first_idx(input logic [LETTERS-1:0] v);
    logic [LETTERS-1:0] oh;
    logic [IdxW-1:0]    r;
    oh = v & (~v + LETTERS'(1));
    r  = '0;
    for (int j = 0; j < LETTERS; j++) begin
      if (oh[j]) r = r | IdxW'(j);
    end
    return r;
  endfunction

endpackage

// ===== rtl/stepping_rotor_cipher_top.sv =====
// Single-rotor stepping cipher.
// Input channel (in_valid_i / in_ready_o / in_req_i): one request per item,
// with an action (encrypt, decrypt, load wiring entry, align), a letter code
// and a wiring slot. Every request gives exactly one result on the output
// channel (out_valid_o / out_ready_i / out_res_o): the cipher or plain letter
// and a found flag; load and align requests return zero.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the align
// key; it is always ready and must only be used while the block is idle.
// Results are registered. Throughput: one request per cycle while in_ready_o
// is high; the whole lookup sits between the request handshake and the result
// register, state updates at acceptance.
// Stall: a two-entry output buffer (result register plus skid) keeps taking
// one more request while a result waits; with both full in_ready_o drops.
// Reset (rst_ni low, async): wiring goes to the default permutation, rotor
// offset to 20 (letter a at position 0), key to 0, output buffer empty.
`include "stepping_rotor_cipher_top_defines.svh"

module stepping_rotor_cipher_top
  import src_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_res_t out_res_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  // Architectural state
  logic [4:0]      wiring_q [LETTERS];
  logic [IdxW-1:0] off_q, off_d;
  logic [IdxW-1:0] key_q;

  // Output buffer
  logic     out_valid_q, skid_valid_q;
  out_res_t out_q, skid_q;

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_q & out_ready_i;

  assign in_ready_o  = ~skid_valid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // Match vectors over the physical wiring entries.
  logic [LETTERS-1:0] hit_letter, hit_zero, ge_mask;
  logic [LETTERS-1:0] srch_vec, hi_vec, sel_vec;
  logic [IdxW-1:0]    off_step, base, hit_idx, rd_addr;
  logic [4:0]         rd_data;
  logic               circ, load_we;
  out_res_t           res;

  assign off_step = add_mod(off_q, IdxW'(1));

  // Encrypt and align search the rotated wiring: a circular first-match starting
  // at the stepped offset for encrypt and at the current offset for align. Decrypt searches the plain wiring from 0.
  always_comb begin
    srch_vec = hit_letter;
    base     = off_step;
    circ     = 1'b1;
    case (in_req_i.action)
      ActEncrypt: begin
        srch_vec = hit_letter;
      end
      ActDecrypt: begin
        circ = 1'b0;
      end
      ActAlign: begin
        srch_vec = hit_zero;
        base     = off_q;
      end
      default: begin
        srch_vec = hit_letter;
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < LETTERS; j++) begin
      hit_letter[j] = (wiring_q[j] == in_req_i.letter);
      hit_zero[j]   = (wiring_q[j] == 5'd0);
      ge_mask[j]    = ((IdxW+1)'(j) >= {1'b0, base});
    end
  end

  assign hi_vec  = circ ? (srch_vec & ge_mask) : srch_vec;
  assign sel_vec = (|hi_vec) ? hi_vec : srch_vec;
  assign hit_idx = first_idx(sel_vec);

  // Single wiring read port: encrypt reads the rotated position back in
  // plain order, decrypt reads the rotated entry at the plain hit.
  always_comb begin
    case (in_req_i.action)
      ActEncrypt: rd_addr = sub_mod(hit_idx, off_step);
      ActDecrypt: rd_addr = add_mod(hit_idx, off_step);
      default:    rd_addr = '0;
    endcase
  end

  assign rd_data = wiring_q[rd_addr];

  always_comb begin
    res     = '0;
    off_d   = off_q;
    load_we = 1'b0;
    case (in_req_i.action)
      ActEncrypt, ActDecrypt: begin
        off_d          = off_step;
        res.found      = |srch_vec;
        res.out_letter = (|srch_vec) ? rd_data : 5'd0;
      end
      ActLoad: begin
        load_we = ({1'b0, in_req_i.slot} < 6'(LETTERS));
      end
      ActAlign: begin
        // offset + pos == hit index, so the new offset is hit - key
        if (|srch_vec) off_d = sub_mod(hit_idx, key_q);
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // State updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LETTERS; i++) begin
        wiring_q[i] <= default_wiring(5'(i));
      end
      off_q <= IdxW'(OffsetReset);
      key_q <= '0;
    end else begin
      if (in_fire) begin
        off_q <= off_d;
        if (load_we) wiring_q[in_req_i.slot[IdxW-1:0]] <= in_req_i.letter;
      end
      if (cfg_valid_i) key_q <= key_mod(cfg_data_i);
    end
  end

  // Output buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire || !out_valid_q) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Output buffer payload
  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (in_fire) out_q <= res;
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  // Assertions
  `SRC_ASSERT_ALWAYS(a_skid_implies_out, skid_valid_q |-> out_valid_q, "skid full, output empty")
  `SRC_ASSERT(a_off_range, off_q < IdxW'(LETTERS), "rotor offset out of range")
  `SRC_ASSERT(a_step, (in_fire && (in_req_i.action == ActEncrypt || in_req_i.action == ActDecrypt)) |=> (off_q == add_mod($past(off_q), IdxW'(1))), "offset did not step")
  `SRC_ASSERT(a_stall_to_skid, (in_fire && out_valid_q && !out_ready_i) |=> skid_valid_q, "stalled request not held")

endmodule
